@@ src/lsbde_pkg.sv @@
package lsbde_pkg;

  localparam int COLOR_W    = 24;
  localparam int DUTY_W     = 16;
  localparam int PERIOD_W   = 17;
  localparam int LED_NUM_W  = 5;
  localparam int SLOT_W     = 5;
  localparam int SLOT_COUNT = 26;

  localparam logic [SLOT_W-1:0]   SLOT_LAST    = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0]   SLOT_FIRST   = '0;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 17'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 17'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd90;
  localparam logic [COLOR_W-1:0]  COLOR_WHITE  = 24'hFFFFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SEND  = 1'b1;

  typedef struct packed {
    logic write;    // store the color of the accepted item
    logic read;     // read the color under the pointer, latch duty values
    logic load;     // load the read color in GRB order, clear slot counter
    logic next;     // one slot delivered, advance to the next
    logic advance;  // LED finished, move the pointer
  } dp_cmd_t;

  typedef struct packed {
    logic last_slot;
  } dp_status_t;

endpackage

@@ src/lsbde_if.sv @@
interface lsbde_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [4:0]                        led_index;
  logic [lsbde_pkg::COLOR_W-1:0]     color;

  modport source (output valid, cmd, led_index, color, input ready);
  modport sink (input valid, cmd, led_index, color, output ready);
endinterface

interface lsbde_out_if;
  logic                              valid;
  logic                              ready;
  logic [lsbde_pkg::DUTY_W-1:0]      duty;
  logic                              last_of_led;
  logic [lsbde_pkg::LED_NUM_W-1:0]   led_number;
  logic                              frame_done;

  modport source (output valid, duty, last_of_led, led_number, frame_done, input ready);
  modport sink (input valid, duty, last_of_led, led_number, frame_done, output ready);
endinterface

interface lsbde_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lsbde_pkg::PERIOD_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/lsbde_ctrl.sv @@
module lsbde_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lsbde_pkg::dp_status_t status,
  output lsbde_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == lsbde_pkg::CMD_SEND) begin
            cmd.read   = 1'b1;
            state_next = S_READ;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_fire) begin
          if (status.last_slot) begin
            cmd.advance = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_EMIT);
    end
  end

endmodule

@@ src/lsbde_dp.sv @@
module lsbde_dp #(
  parameter int LED_NUMBER = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lsbde_pkg::dp_cmd_t                  cmd,
  output lsbde_pkg::dp_status_t               status,
  input  logic [4:0]                          led_index,
  input  logic [lsbde_pkg::COLOR_W-1:0]       color,
  input  logic                                cfg_wr,
  input  logic [lsbde_pkg::PERIOD_W-1:0]      cfg_data,
  output logic [lsbde_pkg::DUTY_W-1:0]        duty,
  output logic                                last_of_led,
  output logic [lsbde_pkg::LED_NUM_W-1:0]     led_number,
  output logic                                frame_done
);

  // Only slots reachable by the 5-bit index are stored; the rest stay white.
  localparam int STORE_DEPTH = (LED_NUMBER < 32) ? LED_NUMBER : 32;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PTR_W       = (LED_NUMBER > 1) ? $clog2(LED_NUMBER) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LED_NUMBER - 1);

  logic [lsbde_pkg::PERIOD_W-1:0] period;
  logic [lsbde_pkg::PERIOD_W-1:0] period_clamped;
  logic [lsbde_pkg::PERIOD_W+1:0] period_x3;
  logic [lsbde_pkg::DUTY_W-1:0]   one_duty_next;
  logic [lsbde_pkg::DUTY_W-1:0]   zero_duty_next;
  logic [lsbde_pkg::DUTY_W-1:0]   one_duty;
  logic [lsbde_pkg::DUTY_W-1:0]   zero_duty;

  logic [lsbde_pkg::COLOR_W-1:0]  mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]         valid;
  logic [lsbde_pkg::COLOR_W-1:0]  rd_color;
  logic                           rd_valid;
  logic [lsbde_pkg::COLOR_W-1:0]  color_eff;

  logic [PTR_W-1:0]               ptr;
  logic [PTR_W-1:0]               led_cur;
  logic [lsbde_pkg::COLOR_W-1:0]  grb;
  logic [lsbde_pkg::SLOT_W-1:0]   slot;
  logic                           wr_en;
  logic                           ptr_in_store;

  always_comb begin
    if (period < lsbde_pkg::PERIOD_MIN) begin
      period_clamped = lsbde_pkg::PERIOD_MIN;
    end else if (period > lsbde_pkg::PERIOD_MAX) begin
      period_clamped = lsbde_pkg::PERIOD_MAX;
    end else begin
      period_clamped = period;
    end
  end

  assign period_x3      = {1'b0, period_clamped, 1'b0} + {2'b00, period_clamped};
  assign one_duty_next  = period_x3[lsbde_pkg::DUTY_W+1:2] - 1'b1;
  assign zero_duty_next = {1'b0, period_clamped[lsbde_pkg::PERIOD_W-1:2]} - 1'b1;

  assign wr_en        = cmd.write && (32'(led_index) < LED_NUMBER);
  assign ptr_in_store = (32'(ptr) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= lsbde_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[led_index[IDX_W-1:0]] <= color;
    end
    if (cmd.read) begin
      rd_color <= mem[ptr[IDX_W-1:0]];
    end
  end

  // Entries not yet written read as white.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[led_index[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.read) begin
        rd_valid <= ptr_in_store && valid[ptr[IDX_W-1:0]];
      end
    end
  end

  assign color_eff = rd_valid ? rd_color : lsbde_pkg::COLOR_WHITE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.advance) begin
      ptr <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      led_cur   <= ptr;
      one_duty  <= one_duty_next;
      zero_duty <= zero_duty_next;
    end
    if (cmd.load) begin
      grb  <= {color_eff[15:8], color_eff[23:16], color_eff[7:0]};
      slot <= lsbde_pkg::SLOT_FIRST;
    end else if (cmd.next) begin
      slot <= slot + 1'b1;
      // hold the first bit through the leading pad slot
      if (slot != lsbde_pkg::SLOT_FIRST) begin
        grb <= {grb[lsbde_pkg::COLOR_W-2:0], 1'b0};
      end
    end
  end

  assign status.last_slot = (slot == lsbde_pkg::SLOT_LAST);

  always_comb begin
    if (slot == lsbde_pkg::SLOT_FIRST || slot == lsbde_pkg::SLOT_LAST) begin
      duty = '0;
    end else begin
      duty = grb[lsbde_pkg::COLOR_W-1] ? one_duty : zero_duty;
    end
  end

  assign last_of_led = status.last_slot;
  assign led_number  = lsbde_pkg::LED_NUM_W'(led_cur);
  assign frame_done  = status.last_slot && (led_cur == PTR_LAST);

endmodule

@@ src/led_strip_bit_duty_encoder_top.sv @@
// Write command: input ready stays high, no result.
// Send command: after the READ state, the first duty slot is valid in S_EMIT; 26 slots
// in all at one per cycle while the sink is ready; input ready returns after the last.
// The slot count per send is set by the 26-step slot counter.
// Reset: synchronous; period 90, pointer 0, all color slots read white at once.
module led_strip_bit_duty_encoder_top #(
  parameter int LED_NUMBER = 32
) (
  input  logic        clk,
  input  logic        rst,
  lsbde_in_if.sink    in_ch,
  lsbde_out_if.source out_ch,
  lsbde_cfg_if.sink   cfg
);

  lsbde_pkg::dp_cmd_t    dp_cmd;
  lsbde_pkg::dp_status_t dp_status;

  assign cfg.ready = !rst;

  lsbde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  lsbde_dp #(
    .LED_NUMBER (LED_NUMBER)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .led_index   (in_ch.led_index),
    .color       (in_ch.color),
    .cfg_wr      (cfg.valid && cfg.ready),
    .cfg_data    (cfg.data),
    .duty        (out_ch.duty),
    .last_of_led (out_ch.last_of_led),
    .led_number  (out_ch.led_number),
    .frame_done  (out_ch.frame_done)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int STRIP_LEN   = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 58;
  localparam int DIR_ROWS    = 27;

  typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic                             cmd;
    logic [4:0]                       idx;
    logic [lsbde_pkg::COLOR_W-1:0]    color;
    logic [lsbde_pkg::PERIOD_W-1:0]   period;
    logic                             fixed;       // duty of every bit slot typed in below
    logic [lsbde_pkg::DUTY_W-1:0]     fixed_duty;
  } row_t;

  typedef struct packed {
    logic [lsbde_pkg::DUTY_W-1:0]    duty;
    logic                            last_slot;
    logic [lsbde_pkg::LED_NUM_W-1:0] led;
    logic                            frame_end;
  } slot_t;

  // Bit slots of a uniform color can be read off directly:
  // P=90 -> one 66, zero 21; P=4 -> one 2, zero 0; P=65536 -> one 49151, zero 16383.
  row_t directed_rows [DIR_ROWS] = '{
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd66},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd31, 24'hFFFFFF, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd1,  24'h123456, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd2,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd21},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd3,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd2},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd131071, 1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd49151},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd6,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd3,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd2},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd65537,  1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd8,  24'hF0A55A, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd65536,  1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd49151},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd4,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd10, 24'h000000, 17'd0,      1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_SEND,  5'd0,  24'h000000, 17'd0,      1'b1, 16'd0},
    '{ROW_PERIOD, lsbde_pkg::CMD_WRITE, 5'd0,  24'h000000, 17'd90,     1'b0, 16'd0},
    '{ROW_ITEM,   lsbde_pkg::CMD_WRITE, 5'd31, 24'h5A3CC3, 17'd0,      1'b0, 16'd0}
  };

  logic clk;
  logic rst;

  lsbde_in_if  in_ch ();
  lsbde_out_if out_ch ();
  lsbde_cfg_if cfg ();

  led_strip_bit_duty_encoder_top #(
    .LED_NUMBER(STRIP_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  // Shadow state of the encoder
  logic [lsbde_pkg::COLOR_W-1:0]   color_mem [STRIP_LEN];
  logic [lsbde_pkg::LED_NUM_W-1:0] send_ptr;
  logic [lsbde_pkg::PERIOD_W-1:0]  period_reg;
  slot_t                           pending_slots [$];

  int  error_count;
  int  write_count;
  int  send_count;
  int  slot_count;
  int  frame_count;
  int  src_idle_pct;
  int  sink_idle_pct;
  logic hold_off_req;
  logic hold_off_taken;
  int  hold_off_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("led_strip_bit_duty_encoder_top regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Work out the 26 slots of the LED under the pointer, then move the pointer
  task automatic encode_next_led(input logic fixed,
                                 input logic [lsbde_pkg::DUTY_W-1:0] fixed_duty);
    int unsigned p;
    logic [lsbde_pkg::DUTY_W-1:0] one_duty;
    logic [lsbde_pkg::DUTY_W-1:0] zero_duty;
    logic [lsbde_pkg::COLOR_W-1:0] grb;
    logic [lsbde_pkg::LED_NUM_W-1:0] led;
    logic last_led;
    slot_t s;
    p = 32'(period_reg);
    if (p < lsbde_pkg::PERIOD_MIN) p = 32'(lsbde_pkg::PERIOD_MIN);
    if (p > lsbde_pkg::PERIOD_MAX) p = 32'(lsbde_pkg::PERIOD_MAX);
    one_duty  = lsbde_pkg::DUTY_W'((3 * p) / 4 - 1);
    zero_duty = lsbde_pkg::DUTY_W'(p / 4 - 1);
    led = send_ptr;
    grb = {color_mem[led][15:8], color_mem[led][23:16], color_mem[led][7:0]};
    last_led = (int'(led) == STRIP_LEN - 1);
    s = '{duty: '0, last_slot: 1'b0, led: led, frame_end: 1'b0};
    pending_slots.push_back(s);
    for (int b = 23; b >= 0; b--) begin
      s.duty = grb[b] ? one_duty : zero_duty;
      if (fixed) s.duty = fixed_duty;
      pending_slots.push_back(s);
    end
    s = '{duty: '0, last_slot: 1'b1, led: led, frame_end: last_led};
    pending_slots.push_back(s);
    send_ptr = last_led ? '0 : led + 1'b1;
  endtask

  task automatic offer_item(input logic cmd, input logic [4:0] idx,
                            input logic [lsbde_pkg::COLOR_W-1:0] color,
                            input logic fixed,
                            input logic [lsbde_pkg::DUTY_W-1:0] fixed_duty);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.led_index <= idx;
    in_ch.color     <= color;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == lsbde_pkg::CMD_WRITE) begin
      if (int'(idx) < STRIP_LEN) color_mem[idx] = color;
      write_count++;
    end else begin
      encode_next_led(fixed, fixed_duty);
      send_count++;
    end
  endtask

  // Drop valid and hold until every slot has come out
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [lsbde_pkg::PERIOD_W-1:0] value);
    drain_outputs();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    period_reg = value;
  endtask

  task automatic random_item();
    logic [lsbde_pkg::COLOR_W-1:0] color;
    int pick;
    pick = $urandom_range(9);
    color = lsbde_pkg::COLOR_W'($urandom());
    if (pick == 0) color = '0;
    else if (pick == 1) color = lsbde_pkg::COLOR_WHITE;
    if ($urandom_range(1) == 1)
      offer_item(lsbde_pkg::CMD_SEND, 5'($urandom()), color, 1'b0, '0);
    else
      offer_item(lsbde_pkg::CMD_WRITE, 5'($urandom()), color, 1'b0, '0);
  endtask

  // Output sink: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_taken) begin
      hold_off_left  = HOLD_CYCLES;
      hold_off_taken = 1'b1;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    slot_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      slot_count++;
      if (out_ch.frame_done) frame_count++;
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("slot with nothing pending: duty %0d led %0d",
                                  out_ch.duty, out_ch.led_number));
      end else begin
        want = pending_slots.pop_front();
        if (out_ch.duty !== want.duty)
          report_mismatch($sformatf("duty %0d, want %0d (led %0d)",
                                    out_ch.duty, want.duty, want.led));
        if (out_ch.last_of_led !== want.last_slot)
          report_mismatch($sformatf("last_of_led %b, want %b (led %0d)",
                                    out_ch.last_of_led, want.last_slot, want.led));
        if (out_ch.led_number !== want.led)
          report_mismatch($sformatf("led_number %0d, want %0d",
                                    out_ch.led_number, want.led));
        if (out_ch.frame_done !== want.frame_end)
          report_mismatch($sformatf("frame_done %b, want %b (led %0d)",
                                    out_ch.frame_done, want.frame_end, want.led));
      end
    end
  end

  initial begin
    logic [lsbde_pkg::PERIOD_W-1:0] phase_period;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = lsbde_pkg::CMD_WRITE;
    in_ch.led_index = '0;
    in_ch.color     = '0;
    cfg.valid       = 1'b0;
    cfg.data        = '0;
    out_ch.ready    = 1'b0;
    hold_off_req    = 1'b0;
    hold_off_taken  = 1'b0;
    hold_off_left   = 0;
    error_count     = 0;
    write_count     = 0;
    send_count      = 0;
    slot_count      = 0;
    frame_count     = 0;
    src_idle_pct    = 33;
    sink_idle_pct   = 70;
    for (int i = 0; i < STRIP_LEN; i++) color_mem[i] = lsbde_pkg::COLOR_WHITE;
    send_ptr   = '0;
    period_reg = lsbde_pkg::PERIOD_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_PERIOD)
        write_period(directed_rows[i].period);
      else
        offer_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].color,
                   directed_rows[i].fixed, directed_rows[i].fixed_duty);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_period = lsbde_pkg::PERIOD_MIN;
        1: phase_period = 17'h1FFFF;
        2: phase_period = 17'($urandom_range(3));
        3: phase_period = lsbde_pkg::PERIOD_MAX;
        4: phase_period = 17'($urandom_range(65535, 5));
        default: phase_period = 17'($urandom_range(131071, 65537));
      endcase
      write_period(phase_period);
      if (ph < 2) begin
        src_idle_pct  = 33;
        sink_idle_pct = 70;
      end else if (ph < 4) begin
        src_idle_pct  = 70;
        sink_idle_pct = 33;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sink off while sends keep coming, so the input backs up
        if (ph == 4 && n == 20) hold_off_req <= 1'b1;
        // stop offering until the output side is empty
        if (ph == 1 && n == 30) drain_outputs();
        random_item();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d writes and %0d sends, %0d slots checked, %0d frame ends",
             write_count, send_count, slot_count, frame_count);
    $display("period swept from 0 to 131071 over three stall mixes, one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (error_count == 0 && pending_slots.size() == 0) begin
      $display("led_strip_bit_duty_encoder_top regression: pass");
    end else begin
      $display("led_strip_bit_duty_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
